// ----- sv/wis_pkg.sv -----
// types and codes shared by the weighted index select block
`timescale 1ns / 1ps

package wis_pkg;

  // command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_DRAW  = 2'd2
  } cmd_e;

  // status codes of a draw result
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_NEG   = 2'd2,
    STAT_OVF   = 2'd3
  } stat_e;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_SCAN,
    ST_EMIT
  } state_e;

  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned FRAC_W   = 32;
  localparam int unsigned INDEX_W  = 6;

  // input transaction payload
  typedef struct packed {
    logic [1:0]                 command;
    logic signed [WEIGHT_W-1:0] weight;
    logic [FRAC_W-1:0]          random_fraction;
  } wis_in_t;

  // result transaction payload
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [1:0]         status;
  } wis_out_t;

endpackage

// ----- sv/weighted_index_select.sv -----
// weighted index select: roulette-wheel selection over a table of q8.8 weights
`timescale 1ns / 1ps

// Roulette-wheel selector. A clear transaction empties the table and the error
// flags, a load transaction appends one Q8.8 weight (negative weights and loads
// into a full table only raise a sticky flag), and a draw transaction returns
// one result: the first entry whose running sum exceeds
// (random_fraction * total) >> 32, or a uniform pick over the entries when all
// weights are zero. Clear, load and unused commands give no result and leave
// the sequencer in idle. A draw that hits an error flag or an empty table goes
// from idle straight to the emit state; a zero-total draw passes through the
// multiply state first; a normal draw also scans the entries up to the
// selected index. The draw time is set by the scan, which reads the weight
// ram one entry per cycle through its single read port after the multiply
// state. A new transaction is taken once the previous draw has placed its
// result in the output register, which may still be waiting for the consumer.
module weighted_index_select
  import wis_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  wis_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output wis_out_t out_data_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TOT_W  = CNT_W + WEIGHT_W - 1;
  localparam int unsigned PROD_W = FRAC_W + TOT_W;
  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_ENTRIES);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic               neg_q, neg_d;
  logic               ovf_q, ovf_d;
  logic [FRAC_W-1:0]  frac_q, frac_d;
  logic [TOT_W-1:0]   target_q, target_d;
  logic [TOT_W-1:0]   accum_q, accum_d;
  logic [IDX_W-1:0]   scan_idx_q, scan_idx_d;
  logic [IDX_W-1:0]   last_nz_q, last_nz_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  stat_e              res_stat_q, res_stat_d;
  logic               out_valid_q, out_valid_d;
  wis_out_t           out_data_q, out_data_d;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_raddr;
  logic [WEIGHT_W-1:0] ram_rdata;
  logic [TOT_W-1:0]    mul_op;
  logic [PROD_W-1:0]   prod;
  logic [TOT_W-1:0]    sum;
  logic                in_fire;
  logic [IDX_W+INDEX_W-1:0] idx_ext;

  // weight store
  wis_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (in_data_i.weight),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // the only write happens in idle, read data is used only outside idle, so no forwarding
  assign ram_we = in_fire && (cmd_e'(in_data_i.command) == CMD_LOAD) &&
                  !in_data_i.weight[WEIGHT_W-1] && (count_q != MaxCnt);

  // shared multiplier: target for a weighted draw, uniform pick otherwise
  assign mul_op = (total_q == '0) ? TOT_W'(count_q) : total_q;
  assign prod   = PROD_W'(frac_q) * PROD_W'(mul_op);

  // running sum of the scan
  assign sum = accum_q + TOT_W'(ram_rdata);

  // result index carries the low six bits of the entry number
  assign idx_ext = {{INDEX_W{1'b0}}, res_idx_q};

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    neg_d       = neg_q;
    ovf_d       = ovf_q;
    frac_d      = frac_q;
    target_d    = target_q;
    accum_d     = accum_q;
    scan_idx_d  = scan_idx_q;
    last_nz_d   = last_nz_q;
    res_idx_d   = res_idx_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    ram_raddr   = scan_idx_q + IDX_W'(1);

    case (state_q)
      ST_IDLE: begin
        ram_raddr = '0;
        if (in_fire) begin
          case (cmd_e'(in_data_i.command))
            CMD_CLEAR: begin
              count_d = '0;
              total_d = '0;
              neg_d   = 1'b0;
              ovf_d   = 1'b0;
            end
            CMD_LOAD: begin
              if (in_data_i.weight[WEIGHT_W-1]) begin
                neg_d = 1'b1;
              end else if (count_q == MaxCnt) begin
                ovf_d = 1'b1;
              end else begin
                total_d = total_q + TOT_W'(in_data_i.weight[WEIGHT_W-2:0]);
                count_d = count_q + CNT_W'(1);
              end
            end
            CMD_DRAW: begin
              frac_d    = in_data_i.random_fraction;
              res_idx_d = '0;
              if (count_q == '0) begin
                res_stat_d = STAT_EMPTY;
                state_d    = ST_EMIT;
              end else if (neg_q) begin
                res_stat_d = STAT_NEG;
                state_d    = ST_EMIT;
              end else if (ovf_q) begin
                res_stat_d = STAT_OVF;
                state_d    = ST_EMIT;
              end else begin
                res_stat_d = STAT_OK;
                state_d    = ST_MULT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_MULT: begin
        // read of entry 0 goes out while the product is formed
        ram_raddr  = '0;
        target_d   = prod[FRAC_W +: TOT_W];
        accum_d    = '0;
        scan_idx_d = '0;
        last_nz_d  = IDX_W'(count_q - CNT_W'(1));
        if (total_q == '0) begin
          res_idx_d = prod[FRAC_W +: IDX_W];
          state_d   = ST_EMIT;
        end else begin
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        accum_d    = sum;
        scan_idx_d = scan_idx_q + IDX_W'(1);
        if (ram_rdata != '0) begin
          last_nz_d = scan_idx_q;
        end
        if (target_q < sum) begin
          res_idx_d = scan_idx_q;
          state_d   = ST_EMIT;
        end else if (CNT_W'(scan_idx_q) == count_q - CNT_W'(1)) begin
          // nothing exceeded the target: fall back to the last nonzero entry
          res_idx_d = (ram_rdata != '0) ? scan_idx_q : last_nz_q;
          state_d   = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_data_d.index  = idx_ext[INDEX_W-1:0];
          out_data_d.status = res_stat_q;
          state_d           = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      neg_q       <= neg_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    frac_q     <= frac_d;
    target_q   <= target_d;
    accum_q    <= accum_d;
    scan_idx_q <= scan_idx_d;
    last_nz_q  <= last_nz_d;
    res_idx_q  <= res_idx_d;
    res_stat_q <= res_stat_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // table never holds more entries than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= MaxCnt)
    else $error("entry count beyond table depth");

  // an empty table has a zero total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> total_q == '0)
    else $error("nonzero total with empty table");

  // the scan never reads past the loaded entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> CNT_W'(scan_idx_q) < count_q)
    else $error("scan beyond entry count");

  // weight ram is written only while no draw is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == ST_IDLE)
    else $error("weight write during a draw");

  // a new result appears only out of the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit");

endmodule

// ----- sv/wis_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module wis_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
